[rtl/pus_pkg.sv]
// Package for the particle update step pipeline.
// Holds shared constants, stage counts and the side-band struct; no dependencies.
package pus_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // Pipeline stage counts
  localparam int SQRT_STAGES = 32;   // one root bit per stage
  localparam int VDIV_STAGES = 63;   // one quotient bit per stage, 63-bit magnitudes
  localparam int PUS_STAGES  = 102;  // input edge to output register

  // Data that rides alongside the long arithmetic units
  typedef struct packed {
    logic        alive;
    logic [31:0] new_age;
    logic        life_zero;
    logic        nz;        // velocity nonzero
    logic [63:0] pos;
    logic [63:0] vel;
    logic [31:0] dt;
    logic [31:0] ang;       // final angle, already selected for dead particles
    logic [3:0]  sgn;       // signs of vx*ra, vy*ta, vy*ra, vx*ta
    logic [63:0] colours;
    logic [63:0] ss;
    logic [63:0] es;
  } side_t;

endpackage

[rtl/pus_delay.sv]
// Fixed-length shift register used to align side data with the arithmetic units.
// Depends on nothing.
module pus_delay #(
  parameter int W = 8,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] line [D];

  always_ff @(posedge clk) begin
    line[0] <= din;
    for (int i = 1; i < D; i++) begin
      line[i] <= line[i-1];
    end
  end

  assign dout = line[D-1];

endmodule

[rtl/pus_udiv.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing; needs rem0 < dvs for an exact quotient.
module pus_udiv #(
  parameter int DW = 32,
  parameter int QW = 17
) (
  input  logic          clk,
  input  logic [DW-1:0] rem0,
  input  logic [QW-1:0] dvd,
  input  logic [DW-1:0] dvs,
  output logic [QW-1:0] quo
);

  logic [DW-1:0] rem   [QW+1];
  logic [QW-1:0] bits  [QW+1];
  logic [QW-1:0] qacc  [QW+1];
  logic [DW-1:0] dvs_s [QW+1];

  assign rem[0]   = rem0;
  assign bits[0]  = dvd;
  assign qacc[0]  = '0;
  assign dvs_s[0] = dvs;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW:0] t;
    logic        ge;
    always_comb begin
      t  = {rem[i], bits[i][QW-1]};
      ge = (t >= {1'b0, dvs_s[i]});
    end
    always_ff @(posedge clk) begin
      rem[i+1]   <= ge ? DW'(t - {1'b0, dvs_s[i]}) : t[DW-1:0];
      bits[i+1]  <= bits[i] << 1;
      qacc[i+1]  <= QW'({qacc[i], ge});
      dvs_s[i+1] <= dvs_s[i];
    end
  end

  assign quo = qacc[QW];

endmodule

[rtl/pus_isqrt.sv]
// Pipelined integer square root of a 64-bit word, one root bit per stage.
// Depends on pus_pkg for the stage count.
module pus_isqrt
  import pus_pkg::*;
(
  input  logic        clk,
  input  logic [63:0] x,
  output logic [31:0] root
);

  logic [33:0] rem  [SQRT_STAGES+1];
  logic [63:0] xs   [SQRT_STAGES+1];
  logic [31:0] racc [SQRT_STAGES+1];

  assign rem[0]  = '0;
  assign xs[0]   = x;
  assign racc[0] = '0;

  for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
    logic [35:0] t;
    logic [35:0] trial;
    logic        ge;
    always_comb begin
      t     = {rem[i], xs[i][63:62]};
      trial = {2'b00, racc[i], 2'b01};
      ge    = (t >= trial);
    end
    always_ff @(posedge clk) begin
      rem[i+1]  <= ge ? 34'(t - trial) : t[33:0];
      xs[i+1]   <= xs[i] << 2;
      racc[i+1] <= {racc[i][30:0], ge};
    end
  end

  assign root = racc[SQRT_STAGES];

endmodule

[rtl/particle_update_step_top.sv]
// Top level of the particle update step pipeline.
// Depends on pus_pkg, pus_delay, pus_udiv and pus_isqrt.
//
// Channel   Direction  Handshake             Payload
// -------   ---------  --------------------  ------------------------------------------
// command   in         start & !busy         elapsed_time .. end_scale
// result    out        done (one cycle)      alive, new_age .. current_scale
//
// One particle may be accepted every cycle; done rises in the same cycle that the
// output register holds the result, and results come out in order. The latency is
// set by the 32-stage square root and the 63-stage velocity dividers, which run back
// to back. busy is only high during reset, which clears the valid chain. The receiver
// cannot stall, so the pipeline never holds.
module particle_update_step_top
  import pus_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        elapsed_time,
  input  logic [31:0]        age,
  input  logic [31:0]        lifetime,
  input  logic [63:0]        position,
  input  logic [63:0]        velocity,
  input  logic [63:0]        angle_spin,
  input  logic [63:0]        accelerations,
  input  logic [63:0]        colours,
  input  logic [63:0]        start_scale,
  input  logic [63:0]        end_scale,
  output logic               done,
  output logic               alive,
  output logic [31:0]        new_age,
  output logic [63:0]        new_position,
  output logic [63:0]        new_velocity,
  output logic signed [31:0] new_angle,
  output logic [31:0]        current_colour,
  output logic [63:0]        current_scale
);

  localparam int KW      = FRAC_BITS + 1;            // k = age/lifetime in Q.F, <= 2^F
  localparam int K_STG   = 2 + KW;                   // stage holding k
  localparam int K_DLY   = 100 - K_STG;              // k needed at stage 100
  localparam int SIDE_W  = $bits(side_t);
  localparam int SIDE_DLY = 2 + SQRT_STAGES + VDIV_STAGES - 2;  // stage 2 to stage 97

  logic accept;
  assign busy   = rst;
  assign accept = start & ~busy;

  // Valid bits travel with the data
  logic [PUS_STAGES:1] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PUS_STAGES-1:1], accept};
    end
  end

  // ---------------- stage 1: age, squares, steering products, spin*dt
  logic [32:0]        age_sum;
  logic [31:0]        age_sat;
  logic signed [31:0] vx_in, vy_in, ra_in, ta_in, spin_in;

  always_comb begin
    age_sum = {1'b0, age} + {1'b0, elapsed_time};
    age_sat = age_sum[32] ? '1 : age_sum[31:0];
    vx_in   = $signed(velocity[63:32]);
    vy_in   = $signed(velocity[31:0]);
    ra_in   = $signed(accelerations[63:32]);
    ta_in   = $signed(accelerations[31:0]);
    spin_in = $signed(angle_spin[31:0]);
  end

  logic [31:0]        s1_new_age, s1_dt, s1_life, s1_ang;
  logic               s1_alive, s1_nz;
  logic [63:0]        s1_sqx, s1_sqy;
  logic signed [63:0] s1_m [4];
  logic signed [64:0] s1_spin;
  logic [63:0]        s1_pos, s1_vel, s1_col, s1_ss, s1_es;

  always_ff @(posedge clk) begin
    s1_new_age <= age_sat;
    s1_alive   <= !(lifetime < age_sat);
    s1_dt      <= elapsed_time;
    s1_life    <= lifetime;
    s1_ang     <= angle_spin[63:32];
    s1_nz      <= (velocity[63:32] != '0) || (velocity[31:0] != '0);
    s1_sqx     <= 64'(vx_in * vx_in);
    s1_sqy     <= 64'(vy_in * vy_in);
    s1_m[0]    <= 64'(vx_in * ra_in);
    s1_m[1]    <= 64'(vy_in * ta_in);
    s1_m[2]    <= 64'(vy_in * ra_in);
    s1_m[3]    <= 64'(vx_in * ta_in);
    s1_spin    <= spin_in * $signed({1'b0, elapsed_time});
    s1_pos     <= position;
    s1_vel     <= velocity;
    s1_col     <= colours;
    s1_ss      <= start_scale;
    s1_es      <= end_scale;
  end

  // ---------------- stage 2: sum of squares, magnitudes, angle
  side_t       s2_side;
  logic [63:0] s2_sum;
  logic [31:0] s2_life;
  logic [62:0] s2_mag [4];

  always_ff @(posedge clk) begin
    s2_sum             <= s1_sqx + s1_sqy;
    s2_life            <= s1_life;
    s2_side.alive      <= s1_alive;
    s2_side.new_age    <= s1_new_age;
    s2_side.life_zero  <= (s1_life == '0);
    s2_side.nz         <= s1_nz;
    s2_side.pos        <= s1_pos;
    s2_side.vel        <= s1_vel;
    s2_side.dt         <= s1_dt;
    s2_side.ang        <= s1_alive ? s1_ang + s1_spin[FRAC_BITS+31:FRAC_BITS] : s1_ang;
    s2_side.colours    <= s1_col;
    s2_side.ss         <= s1_ss;
    s2_side.es         <= s1_es;
    for (int i = 0; i < 4; i++) begin
      s2_side.sgn[i] <= s1_m[i][63];
      s2_mag[i]      <= s1_m[i][63] ? 63'(-s1_m[i]) : s1_m[i][62:0];
    end
  end

  // ---------------- k = floor(new_age * 2^F / lifetime)
  logic [KW-1:0] k_q, k100;

  pus_udiv #(.DW(32), .QW(KW)) u_kdiv (
    .clk  (clk),
    .rem0 ({1'b0, s2_side.new_age[31:1]}),
    .dvd  ({s2_side.new_age[0], {FRAC_BITS{1'b0}}}),
    .dvs  (s2_life),
    .quo  (k_q)
  );

  pus_delay #(.W(KW), .D(K_DLY)) u_kdly (
    .clk  (clk),
    .din  (k_q),
    .dout (k100)
  );

  // ---------------- |v| and the four steering quotients
  logic [31:0] len34;
  logic [62:0] mag34 [4];
  logic [62:0] quo97 [4];

  pus_isqrt u_sqrt (
    .clk  (clk),
    .x    (s2_sum),
    .root (len34)
  );

  for (genvar i = 0; i < 4; i++) begin : g_vdiv
    pus_delay #(.W(63), .D(SQRT_STAGES)) u_mdly (
      .clk  (clk),
      .din  (s2_mag[i]),
      .dout (mag34[i])
    );
    pus_udiv #(.DW(32), .QW(VDIV_STAGES)) u_div (
      .clk  (clk),
      .rem0 ('0),
      .dvd  (mag34[i]),
      .dvs  (len34),
      .quo  (quo97[i])
    );
  end

  logic [SIDE_W-1:0] side97_bits;
  side_t             side97;

  pus_delay #(.W(SIDE_W), .D(SIDE_DLY)) u_side_dly (
    .clk  (clk),
    .din  (s2_side),
    .dout (side97_bits)
  );
  assign side97 = side_t'(side97_bits);

  // ---------------- stage 98: combine radial and tangential terms
  logic signed [63:0] qs [4];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qs[i] = side97.sgn[i] ? -$signed({1'b0, quo97[i]}) : $signed({1'b0, quo97[i]});
    end
  end

  side_t       side98;
  logic [63:0] ax98, ay98;
  always_ff @(posedge clk) begin
    side98 <= side97;
    ax98   <= side97.nz ? 64'(qs[0] - qs[1]) : '0;
    ay98   <= side97.nz ? 64'(qs[2] + qs[3]) : '0;
  end

  // ---------------- stage 99: acceleration times dt, split in two products
  side_t       side99;
  logic [63:0] p0x, p0y;
  logic [31:0] p1x, p1y;
  always_ff @(posedge clk) begin
    side99 <= side98;
    p0x    <= ax98[31:0] * side98.dt;
    p0y    <= ay98[31:0] * side98.dt;
    p1x    <= 32'(ax98[63:32] * side98.dt);
    p1y    <= 32'(ay98[63:32] * side98.dt);
  end

  // ---------------- stage 100: new velocity
  side_t       side100;
  logic [31:0] vx100, vy100;
  logic [31:0] p1x_sh, p1y_sh;
  always_comb begin
    p1x_sh = p1x << (32 - FRAC_BITS);
    p1y_sh = p1y << (32 - FRAC_BITS);
  end
  always_ff @(posedge clk) begin
    side100 <= side99;
    vx100   <= side99.vel[63:32] + p0x[FRAC_BITS+31:FRAC_BITS] + p1x_sh;
    vy100   <= side99.vel[31:0] + p0y[FRAC_BITS+31:FRAC_BITS] + p1y_sh;
  end

  // ---------------- stage 101: velocity*dt and interpolation products
  side_t                 side101;
  logic [31:0]           vx101, vy101;
  logic signed [64:0]    pvx, pvy;
  logic signed [KW+9:0]  cprod [4];
  logic signed [KW+33:0] sprod [2];
  logic [KW-1:0]         k_eff;
  logic signed [8:0]     cdiff [4];
  logic signed [32:0]    sdiff [2];

  always_comb begin
    k_eff = side100.life_zero ? '0 : k100;
    for (int i = 0; i < 4; i++) begin
      cdiff[i] = $signed({1'b0, side100.colours[8*i +: 8]})
               - $signed({1'b0, side100.colours[32+8*i +: 8]});
    end
    for (int i = 0; i < 2; i++) begin
      sdiff[i] = $signed({side100.es[32*i+31], side100.es[32*i +: 32]})
               - $signed({side100.ss[32*i+31], side100.ss[32*i +: 32]});
    end
  end

  always_ff @(posedge clk) begin
    side101 <= side100;
    vx101   <= vx100;
    vy101   <= vy100;
    pvx     <= $signed(vx100) * $signed({1'b0, side100.dt});
    pvy     <= $signed(vy100) * $signed({1'b0, side100.dt});
    for (int i = 0; i < 4; i++) begin
      cprod[i] <= cdiff[i] * $signed({1'b0, k_eff});
    end
    for (int i = 0; i < 2; i++) begin
      sprod[i] <= sdiff[i] * $signed({1'b0, k_eff});
    end
  end

  // ---------------- stage 102: position, interpolation sums, output register
  logic signed [KW+9:0]  csh [4];
  logic signed [KW+33:0] ssh [2];
  logic [31:0]           colour_c;
  logic [63:0]           scale_c;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      csh[i] = cprod[i] >>> FRAC_BITS;
      colour_c[8*i +: 8] = side101.colours[32+8*i +: 8] + csh[i][7:0];
    end
    for (int i = 0; i < 2; i++) begin
      ssh[i] = sprod[i] >>> FRAC_BITS;
      scale_c[32*i +: 32] = side101.ss[32*i +: 32] + ssh[i][31:0];
    end
  end

  always_ff @(posedge clk) begin
    alive     <= side101.alive;
    new_age   <= side101.new_age;
    new_angle <= $signed(side101.ang);
    if (side101.alive) begin
      new_position   <= {side101.pos[63:32] + pvx[FRAC_BITS+31:FRAC_BITS],
                         side101.pos[31:0] + pvy[FRAC_BITS+31:FRAC_BITS]};
      new_velocity   <= {vx101, vy101};
      current_colour <= colour_c;
      current_scale  <= scale_c;
    end else begin
      new_position   <= side101.pos;
      new_velocity   <= side101.vel;
      current_colour <= '0;
      current_scale  <= '0;
    end
  end

  assign done = vld[PUS_STAGES];

endmodule

[rtl/pus_chk.sv]
// Port-level checker for the particle update step pipeline, bound to the top level.
// Depends on pus_pkg for the pipeline depth.
module pus_chk
  import pus_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [31:0] elapsed_time,
  input logic [31:0] age,
  input logic [31:0] lifetime,
  input logic        done,
  input logic        alive,
  input logic [31:0] new_age,
  input logic [31:0] current_colour,
  input logic [63:0] current_scale
);

  // done must be matched by an input transfer at the head of the valid chain
  localparam int LAT = PUS_STAGES;

  a_lat : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a matching transfer");

  a_age : assert property (@(posedge clk) disable iff (rst)
    done |-> (new_age == (({1'b0, $past(age, LAT)} + {1'b0, $past(elapsed_time, LAT)}) > 33'hFFFF_FFFF
              ? 32'hFFFF_FFFF : 32'($past(age, LAT) + $past(elapsed_time, LAT)))))
    else $error("new_age mismatch");

  a_alive : assert property (@(posedge clk) disable iff (rst)
    done |-> (alive == !($past(lifetime, LAT) < new_age)))
    else $error("alive flag mismatch");

  a_dead : assert property (@(posedge clk) disable iff (rst)
    (done && !alive) |-> (current_colour == '0 && current_scale == '0))
    else $error("dead particle with nonzero colour or scale");

endmodule

bind particle_update_step_top pus_chk u_pus_chk (.*);
